### src/tdpt_pkg.sv
// shared types and constants for the trial division prime test unit
// no dependencies; imported by every module of the block
`default_nettype none

package tdpt_pkg;

    // operand width: the low bits of the candidate that are tested, top bit is the sign
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // status of the shared divider as seen by the sequencer
    typedef struct packed {
        logic   busy;
        logic   done;
        value_t quotient;
        value_t remainder;
    } div_status_t;

endpackage

`default_nettype wire

### src/tdpt_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on tdpt_pkg for the operand width and the status struct
`default_nettype none

module tdpt_divider
    import tdpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire value_t      dividend,
    input  wire value_t      divisor,
    output div_status_t      status
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    value_t           rem_reg, rem_next;
    value_t           quo_reg, quo_next;
    value_t           div_reg, div_next;

    logic [VALUE_WIDTH:0] shifted;
    logic [VALUE_WIDTH:0] diff;
    logic                 ge;

    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(VALUE_WIDTH - 1);
            rem_next   = '0;
            quo_next   = dividend;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out of the top while quotient bits enter below
            rem_next = ge ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign status.busy      = busy_reg;
    assign status.done      = done_reg;
    assign status.quotient  = quo_reg;
    assign status.remainder = rem_reg;

endmodule

`default_nettype wire

### src/trial_division_prime_test_unit.sv
// top level of the trial division prime test: sequencer, result register, divider instance
// depends on tdpt_pkg and tdpt_divider
//
// usage:
//   input channel in_valid / in_ready carries candidate, a signed value whose
//   low VALUE_WIDTH bits are tested. output channel out_valid / out_ready
//   carries is_prime, exactly one beat per input beat, in order.
//   negative values, zero and one give 0, two and three give 1 without a division;
//   the result goes via the wait state to the output register, then in_ready rises.
//   other values are divided by d = 2, 3, 4, ... on one shared restoring divider.
//   each trial divisor costs a load step on the divider plus one quotient bit per
//   cycle; the same division gives n / d for the bound test d > n / d and n % d
//   for the factor test. a 31-bit prime takes up to about 46341 trial divisors.
//   in_ready is high only while no item is in work; one item at a time.
//   the result sits in an output register, so a new beat may be accepted
//   while the previous result still waits; a finished result waits in the
//   sequencer if the output register is still full.
//   reset (rst_n low, asynchronous) drops every item in work and clears out_valid.
`default_nettype none

module trial_division_prime_test_unit
    import tdpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] candidate,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             is_prime
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_bit_reg, out_bit_next;
    logic        res_reg, res_next;
    value_t      n_reg, n_next;
    value_t      d_reg, d_next;

    logic        div_start;
    value_t      div_dividend;
    value_t      div_divisor;
    div_status_t div_status;

    value_t      value;
    logic        accept;
    logic        slot_free;
    value_t      d_inc;

    assign value     = candidate[VALUE_WIDTH-1:0];
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign d_inc     = d_reg + VALUE_WIDTH'(1);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_bit_next   = out_bit_reg;
        res_next       = res_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        div_start      = 1'b0;
        div_dividend   = n_reg;
        div_divisor    = d_inc;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next = value;
                    priority if (value[VALUE_WIDTH-1] || value <= VALUE_WIDTH'(1))
                    begin
                        res_next   = 1'b0;
                        state_next = S_WAIT;
                    end
                    else if (value == VALUE_WIDTH'(2) || value == VALUE_WIDTH'(3))
                    begin
                        res_next   = 1'b1;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        d_next       = VALUE_WIDTH'(2);
                        div_start    = 1'b1;
                        div_dividend = value;
                        div_divisor  = VALUE_WIDTH'(2);
                        state_next   = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (div_status.done)
                begin
                    // bound first: once d exceeds n / d no factor is left
                    priority if (d_reg > div_status.quotient)
                    begin
                        res_next   = 1'b1;
                        state_next = S_WAIT;
                    end
                    else if (div_status.remainder == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        d_next    = d_inc;
                        div_start = 1'b1;
                    end
                end
            end
            S_WAIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg <= out_bit_next;
        res_reg     <= res_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
    end

    tdpt_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = out_bit_reg;

    // no new beat is taken while the divider still works on the previous one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_status.busy && !div_status.done)
        else $error("input ready while divider active");

    // a finished division only ever arrives while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == S_RUN)
        else $error("divider done outside run state");

    // trial divisors start at two
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> d_reg >= VALUE_WIDTH'(2))
        else $error("trial divisor below two");

    // a negative candidate is settled at once as not prime
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && value[VALUE_WIDTH-1] |=> state_reg == S_WAIT && !res_reg)
        else $error("negative candidate not rejected");

endmodule

`default_nettype wire

### tb/trial_division_prime_test_checker.sv
// scoreboard for the trial division prime test unit: predicts is_prime per input beat
// and compares it with each output beat in order; depends on tdpt_pkg
`timescale 1ns / 1ps

module trial_division_prime_test_checker
    import tdpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] candidate,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        is_prime,
    output int          flag_mismatches,
    output int          flags_waiting,
    output int          flags_checked,
    output int          primes_seen
);

    bit prime_flags_due[$];

    // low VALUE_WIDTH bits are the value, the top one of them is the sign
    function automatic bit prime_by_trial_division(logic [31:0] raw);
        value_t          v;
        longint unsigned n;
        longint unsigned d;
        v = raw[VALUE_WIDTH-1:0];
        if (v[VALUE_WIDTH-1])
            return 1'b0;
        n = v;
        if (n <= 1)
            return 1'b0;
        if (n == 2 || n == 3)
            return 1'b1;
        // d <= n / d keeps the bound free of overflow
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        bit want;
        if (!rst_n)
        begin
            prime_flags_due.delete();
            flag_mismatches = 0;
            flags_waiting   = 0;
            flags_checked   = 0;
            primes_seen     = 0;
        end
        else
        begin
            // retire the output beat first so a beat never meets its own prediction
            if (out_valid && out_ready)
            begin
                if (prime_flags_due.size() == 0)
                begin
                    if (flag_mismatches < 10)
                        $display("%0t: output beat is_prime=%b with nothing expected",
                                 $realtime, is_prime);
                    flag_mismatches++;
                end
                else
                begin
                    want = prime_flags_due.pop_front();
                    if (is_prime !== want)
                    begin
                        if (flag_mismatches < 10)
                            $display("%0t: is_prime expected %b, got %b",
                                     $realtime, want, is_prime);
                        flag_mismatches++;
                    end
                    flags_checked++;
                    if (is_prime === 1'b1)
                        primes_seen++;
                end
            end
            if (in_valid && in_ready)
                prime_flags_due = {prime_flags_due, prime_by_trial_division(candidate)};
            flags_waiting = prime_flags_due.size();
        end
    end

endmodule

### tb/trial_division_prime_test_unit_tb.sv
// testbench top for the trial division prime test unit: clock, reset, stimulus, verdict
// depends on trial_division_prime_test_unit, trial_division_prime_test_checker and tdpt_pkg
`timescale 1ns / 1ps

module trial_division_prime_test_unit_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] candidate;
    logic        out_valid;
    logic        out_ready;
    logic        is_prime;

    int flag_mismatches;
    int flags_waiting;
    int flags_checked;
    int primes_seen;
    int candidates_sent;
    bit no_gaps;

    // extremes, squares of primes right at the divisor bound, negatives, big primes
    logic [31:0] directed_values [21] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd97,
        32'd121, 32'd65521, 32'd65537, 32'd1000003, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
        32'h4000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD
    };

    trial_division_prime_test_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_prime  (is_prime)
    );

    trial_division_prime_test_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .candidate       (candidate),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .is_prime        (is_prime),
        .flag_mismatches (flag_mismatches),
        .flags_waiting   (flags_waiting),
        .flags_checked   (flags_checked),
        .primes_seen     (primes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #160_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // mostly small values and negatives; large positive ones always carry a factor of 7 or less
    function automatic logic [31:0] draw_candidate();
        int unsigned pick;
        int unsigned p;
        int unsigned q;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return $urandom_range(0, 4095);
        if (pick < 60)
            return $urandom_range(0, 1 << 20);
        if (pick < 72)
        begin
            p = $urandom_range(2, 1000);
            q = (pick < 66) ? p : $urandom_range(2, 1000);
            return p * q;
        end
        if (pick < 86)
            return {1'b1, 31'($urandom)};
        p = $urandom_range(2, 7);
        return $urandom_range(0, 32'h7FFF_FFFF / p) * p;
    endfunction

    // entered and left at a falling edge
    task automatic send_candidate(input logic [31:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        candidates_sent++;
        @(negedge clk);
    endtask

    // receiver: either ready ahead of the result, or holds the result back for a random stall
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
                while (!out_valid)
                    @(posedge clk);
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        candidate       = '0;
        out_ready       = 1'b0;
        candidates_sent = 0;
        no_gaps         = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_values[i])
            send_candidate(directed_values[i]);

        // random beats in four phases, the second one back to back
        for (int phase = 0; phase < 4; phase++)
        begin
            no_gaps = (phase == 1);
            for (int k = 0; k < 20; k++)
                send_candidate(draw_candidate());
        end
        no_gaps  = 1'b0;
        in_valid <= 1'b0;

        while (flags_waiting != 0)
            @(posedge clk);
        // anything arriving now would be an extra beat
        repeat (200) @(posedge clk);

        $display("sent %0d candidates (negatives, 0..5, prime squares, 2^31-1, random mix)",
                 candidates_sent);
        $display("checked %0d results, %0d of them prime, %0d mismatches",
                 flags_checked, primes_seen, flag_mismatches);
        if (flag_mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
